// File: hdl/two_class_priority_deque_defines.svh
// Assertion macros for the two-class priority deque.
`ifndef TWO_CLASS_PRIORITY_DEQUE_DEFINES_SVH
`define TWO_CLASS_PRIORITY_DEQUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TCPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TCPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tcpd_pkg.sv
// Shared types and codes for the two-class priority deque.
package tcpd_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT  = 3'd0,
        OP_PUSH_BACK   = 3'd1,
        OP_POP_FRONT   = 3'd2,
        OP_POP_BACK    = 3'd3,
        OP_PUSH_URGENT = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] entry_data;
        logic        entry_critical;
    } cmd_t;

    typedef struct packed {
        logic [31:0] front_data;
        logic        front_critical;
        logic [31:0] back_data;
        logic        back_critical;
        logic [4:0]  occupancy;
        logic        is_empty;
        logic [1:0]  op_status;
    } result_t;

    typedef struct packed {
        logic add_front;
        logic add_back;
        logic take_front;
        logic push_urgent;
    } cell_ctl_t;

endpackage

// File: hdl/two_class_priority_deque.sv
// Top level of the two-class priority deque: control, count and a chain of slot cells.
// The result beat appears in the cycle after start is taken, with done high for one cycle.
// Throughput: one operation per cycle; busy stays low, and all cells update in the same cycle.
// The critical-run search and back-entry select ripple through the cell chain.
// Reset: rst_n clears the count, status and done; slot contents are not cleared.
// The receiver cannot stall: each result beat is taken in the cycle it is shown.
`include "two_class_priority_deque_defines.svh"

module two_class_priority_deque #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tcpd_pkg::cmd_t    cmd,
    output logic              done,
    output tcpd_pkg::result_t result
);
    import tcpd_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] count_reg, count_next;
    status_t       status_reg, status_next;
    logic          done_reg;

    logic          accept;
    logic          full;
    logic          empty;
    cell_ctl_t     ctl;

    logic [DATA_WIDTH-1:0] push_data;
    logic [DATA_WIDTH-1:0] cell_data  [CAPACITY];
    logic                  cell_crit  [CAPACITY];
    logic [DATA_WIDTH-1:0] left_data  [CAPACITY];
    logic                  left_crit  [CAPACITY];
    logic [DATA_WIDTH-1:0] right_data [CAPACITY];
    logic                  right_crit [CAPACITY];
    logic                  run_chain  [CAPACITY+1];
    logic [DATA_WIDTH-1:0] bdata_chain [CAPACITY+1];
    logic                  bcrit_chain [CAPACITY+1];

    assign busy      = 1'b0;
    assign accept    = start & ~busy;
    assign full      = count_reg == CW'(CAPACITY);
    assign empty     = count_reg == '0;
    assign push_data = DATA_WIDTH'(cmd.entry_data);

    always_comb
    begin
        ctl         = '0;
        count_next  = count_reg;
        status_next = ST_DONE;
        if (accept)
        begin
            unique case (cmd.opcode) inside
                OP_PUSH_FRONT, OP_PUSH_BACK, OP_PUSH_URGENT:
                begin
                    if (full)
                    begin
                        status_next = ST_PUSH_FULL;
                    end
                    else
                    begin
                        ctl.add_front   = cmd.opcode == OP_PUSH_FRONT;
                        ctl.add_back    = cmd.opcode == OP_PUSH_BACK;
                        ctl.push_urgent = cmd.opcode == OP_PUSH_URGENT;
                        count_next      = count_reg + CW'(1);
                    end
                end
                OP_POP_FRONT, OP_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = ST_POP_EMPTY;
                    end
                    else
                    begin
                        ctl.take_front = cmd.opcode == OP_POP_FRONT;
                        count_next     = count_reg - CW'(1);
                    end
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            status_reg <= ST_DONE;
            done_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            status_reg <= status_next;
            done_reg   <= accept;
        end
    end

    assign run_chain[0]   = 1'b1;
    assign bdata_chain[0] = '0;
    assign bcrit_chain[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            assign left_data[g] = push_data;
            assign left_crit[g] = cmd.entry_critical;
        end
        else
        begin : g_mid
            assign left_data[g] = cell_data[g-1];
            assign left_crit[g] = cell_crit[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_tail
            assign right_data[g] = '0;
            assign right_crit[g] = 1'b0;
        end
        else
        begin : g_body
            assign right_data[g] = cell_data[g+1];
            assign right_crit[g] = cell_crit[g+1];
        end

        tcpd_cell #(
            .IDX        (g),
            .CW         (CW),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk           (clk),
            .ctl           (ctl),
            .count         (count_reg),
            .ins_data      (push_data),
            .ins_crit      (cmd.entry_critical),
            .left_data     (left_data[g]),
            .left_crit     (left_crit[g]),
            .right_data    (right_data[g]),
            .right_crit    (right_crit[g]),
            .run_in        (run_chain[g]),
            .run_out       (run_chain[g+1]),
            .back_data_in  (bdata_chain[g]),
            .back_crit_in  (bcrit_chain[g]),
            .back_data_out (bdata_chain[g+1]),
            .back_crit_out (bcrit_chain[g+1]),
            .data          (cell_data[g]),
            .crit          (cell_crit[g])
        );
    end

    assign done                  = done_reg;
    assign result.front_data     = empty ? '0 : 32'(cell_data[0]);
    assign result.front_critical = ~empty & cell_crit[0];
    assign result.back_data      = 32'(bdata_chain[CAPACITY]);
    assign result.back_critical  = bcrit_chain[CAPACITY];
    assign result.occupancy      = 5'(count_reg);
    assign result.is_empty       = empty;
    assign result.op_status      = status_reg;

    `TCPD_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY), "count above capacity")
    `TCPD_ASSERT_NEXT(a_one_result, accept, done, "accepted beat gave no result")
    `TCPD_ASSERT_NOW(a_full_drop, done && status_reg == ST_PUSH_FULL, full, "drop while not full")
    `TCPD_ASSERT_NOW(a_empty_pop, done && status_reg == ST_POP_EMPTY, empty, "bad pop status")
    `TCPD_ASSERT_NOW(a_empty_view, empty, {result.back_data, result.back_critical} == '0, "back set")

endmodule

// File: hdl/tcpd_cell.sv
// One slot of the deque chain: holds an entry and shifts with its neighbors.
module tcpd_cell #(
    parameter int IDX        = 0,
    parameter int CW         = 5,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  tcpd_pkg::cell_ctl_t   ctl,
    input  logic [CW-1:0]         count,
    input  logic [DATA_WIDTH-1:0] ins_data,
    input  logic                  ins_crit,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic                  left_crit,
    input  logic [DATA_WIDTH-1:0] right_data,
    input  logic                  right_crit,
    input  logic                  run_in,
    output logic                  run_out,
    input  logic [DATA_WIDTH-1:0] back_data_in,
    input  logic                  back_crit_in,
    output logic [DATA_WIDTH-1:0] back_data_out,
    output logic                  back_crit_out,
    output logic [DATA_WIDTH-1:0] data,
    output logic                  crit
);
    import tcpd_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic                  crit_reg, crit_next;
    logic                  occupied;
    logic                  is_last;
    logic                  in_run;

    assign occupied = count > CW'(IDX);
    assign is_last  = count == CW'(IDX + 1);
    assign in_run   = occupied & crit_reg;
    assign run_out  = run_in & in_run;

    assign back_data_out = back_data_in | (is_last ? data_reg : '0);
    assign back_crit_out = back_crit_in | (is_last & crit_reg);

    assign data = data_reg;
    assign crit = crit_reg;

    always_comb
    begin
        data_next = data_reg;
        crit_next = crit_reg;
        if (ctl.add_front)
        begin
            if (IDX == 0)
            begin
                data_next = ins_data;
                crit_next = ins_crit;
            end
            else
            begin
                data_next = left_data;
                crit_next = left_crit;
            end
        end
        else if (ctl.add_back)
        begin
            if (count == CW'(IDX))
            begin
                data_next = ins_data;
                crit_next = ins_crit;
            end
        end
        else if (ctl.take_front)
        begin
            data_next = right_data;
            crit_next = right_crit;
        end
        else if (ctl.push_urgent)
        begin
            // insertion point: first cell past the critical run
            if (run_in && !in_run)
            begin
                data_next = ins_data;
                crit_next = ins_crit;
            end
            else if (!run_in)
            begin
                data_next = left_data;
                crit_next = left_crit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        crit_reg <= crit_next;
    end

endmodule

// File: dv/tb_two_class_priority_deque.sv
// Testbench for the two-class priority deque: directed and random commands against a predictor.
`timescale 1ns / 1ps

module tb_two_class_priority_deque;
    import tcpd_pkg::*;

    localparam int DEPTH = 16;
    localparam int STIM_COUNT = 2000;
    localparam int SEGMENT_LEN = 60;
    localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [2:0] OP_RSVD_MID = 3'd6;
    localparam logic [2:0] OP_RSVD_LAST = 3'd7;

    typedef struct packed {
        logic [31:0] data;
        logic        crit;
    } slot_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    done;
    result_t result;

    slot_t   deque_model[$];
    result_t pending_views[$];
    int      mismatches;
    bit      gaps_on;

    two_class_priority_deque #(
        .CAPACITY(DEPTH),
        .DATA_WIDTH(32)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .done(done),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(400_000 * 20);
        $display("[two_class_priority_deque] ERROR");
        $finish;
    end

    // Apply one command to the model deque and return the view it leaves.
    function automatic result_t predict_view(cmd_t c);
        result_t v;
        slot_t   e;
        status_t st;
        int      run;
        st = ST_DONE;
        e.data = c.entry_data;
        e.crit = c.entry_critical;
        case (c.opcode)
            OP_PUSH_FRONT:
                if (deque_model.size() >= DEPTH) st = ST_PUSH_FULL;
                else deque_model.insert(0, e);
            OP_PUSH_BACK:
                if (deque_model.size() >= DEPTH) st = ST_PUSH_FULL;
                else deque_model.insert(deque_model.size(), e);
            OP_POP_FRONT:
                if (deque_model.size() == 0) st = ST_POP_EMPTY;
                else deque_model.delete(0);
            OP_POP_BACK:
                if (deque_model.size() == 0) st = ST_POP_EMPTY;
                else deque_model.delete(deque_model.size() - 1);
            OP_PUSH_URGENT:
                if (deque_model.size() >= DEPTH) st = ST_PUSH_FULL;
                else
                begin
                    run = 0;
                    while (run < deque_model.size() && deque_model[run].crit) run++;
                    deque_model.insert(run, e);
                end
            default: ;
        endcase
        v = '0;
        if (deque_model.size() != 0)
        begin
            v.front_data     = deque_model[0].data;
            v.front_critical = deque_model[0].crit;
            v.back_data      = deque_model[deque_model.size() - 1].data;
            v.back_critical  = deque_model[deque_model.size() - 1].crit;
        end
        v.occupancy = 5'(deque_model.size());
        v.is_empty  = (deque_model.size() == 0);
        v.op_status = st;
        return v;
    endfunction

    task automatic send_cmd(input logic [2:0] op, input logic [31:0] data, input logic crit);
        cmd_t c;
        c.opcode = op;
        c.entry_data = data;
        c.entry_critical = crit;
        while (gaps_on && $urandom_range(0, 99) < 17)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (busy);
        pending_views.insert(pending_views.size(), predict_view(c));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
        if (exp !== act)
        begin
            mismatches++;
            $display("%0t %s mismatch: expected %h actual %h", $time, name, exp, act);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_views.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected result beat: expected none actual %h", $time, result);
            end
            else
            begin
                want = pending_views[0];
                pending_views.delete(0);
                check_field("front_data", want.front_data, result.front_data);
                check_field("front_critical", 32'(want.front_critical),
                            32'(result.front_critical));
                check_field("back_data", want.back_data, result.back_data);
                check_field("back_critical", 32'(want.back_critical),
                            32'(result.back_critical));
                check_field("occupancy", 32'(want.occupancy), 32'(result.occupancy));
                check_field("is_empty", 32'(want.is_empty), 32'(result.is_empty));
                check_field("op_status", 32'(want.op_status), 32'(result.op_status));
            end
        end
    end

    task automatic test_empty_and_unused();
        send_cmd(OP_POP_FRONT, 32'h1234_5678, 1'b1);
        send_cmd(OP_POP_BACK, 32'hFFFF_FFFF, 1'b0);
        send_cmd(OP_RSVD_FIRST, 32'hFFFF_FFFF, 1'b1);
        send_cmd(OP_RSVD_MID, 32'h0000_0000, 1'b0);
        send_cmd(OP_RSVD_LAST, 32'hDEAD_BEEF, 1'b1);
    endtask

    task automatic test_push_pop_extremes();
        send_cmd(OP_PUSH_FRONT, 32'h0000_0000, 1'b0);
        send_cmd(OP_PUSH_BACK, 32'hFFFF_FFFF, 1'b1);
        send_cmd(OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1);
        send_cmd(OP_POP_BACK, 32'h0000_0000, 1'b0);
        send_cmd(OP_POP_FRONT, 32'h0000_0000, 1'b0);
        send_cmd(OP_POP_FRONT, 32'h0000_0000, 1'b0);
    endtask

    task automatic test_urgent_order();
        // critical run at the front: urgent entry lands just past its end
        send_cmd(OP_PUSH_URGENT, 32'h0000_0010, 1'b1);
        send_cmd(OP_PUSH_URGENT, 32'h0000_0011, 1'b1);
        send_cmd(OP_PUSH_URGENT, 32'h0000_0012, 1'b0);
        send_cmd(OP_PUSH_URGENT, 32'h0000_0013, 1'b1);
        // non-critical front: urgent entry goes to the front
        send_cmd(OP_PUSH_FRONT, 32'h0000_0014, 1'b0);
        send_cmd(OP_PUSH_URGENT, 32'h0000_0015, 1'b1);
        send_cmd(OP_RSVD_LAST, 32'hA5A5_A5A5, 1'b0);
    endtask

    task automatic test_random_mix();
        logic [2:0]  op;
        logic [31:0] data;
        int          r;
        int          pick;
        bit          filling;
        filling = 1'b1;
        for (int n = 0; n < STIM_COUNT; n++)
        begin
            if (n % SEGMENT_LEN == 0 && n != 0)
                filling = ($urandom_range(0, 2) != 0) ? ~filling : filling;
            gaps_on = !(n >= 800 && n < 1200);
            if (n == 500 || n == 1500)
                drain_results();
            r = $urandom_range(0, 99);
            if (filling)
            begin
                if (r < 25) op = OP_PUSH_FRONT;
                else if (r < 50) op = OP_PUSH_BACK;
                else if (r < 75) op = OP_PUSH_URGENT;
                else if (r < 87) op = OP_POP_FRONT;
                else if (r < 97) op = OP_POP_BACK;
                else op = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
            end
            else
            begin
                if (r < 10) op = OP_PUSH_FRONT;
                else if (r < 20) op = OP_PUSH_BACK;
                else if (r < 30) op = OP_PUSH_URGENT;
                else if (r < 63) op = OP_POP_FRONT;
                else if (r < 96) op = OP_POP_BACK;
                else op = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
            end
            pick = $urandom_range(0, 7);
            if (pick == 0) data = 32'h0000_0000;
            else if (pick == 1) data = 32'hFFFF_FFFF;
            else data = $urandom;
            send_cmd(op, data, 1'($urandom_range(0, 1)));
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        mismatches = 0;
        gaps_on = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_unused();
        test_push_pop_extremes();
        test_urgent_order();
        test_random_mix();

        drain_results();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("[two_class_priority_deque] OK");
        else
            $display("[two_class_priority_deque] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/tcpd_pkg.sv
hdl/tcpd_cell.sv
hdl/two_class_priority_deque.sv
dv/tb_two_class_priority_deque.sv
